// ===== rtl/gbh_pkg.sv =====
// ----------------------------------------------------------------------------
// Gray binned histogram package
// Shared types, operation codes and constants for the gray binned histogram.
// ----------------------------------------------------------------------------
package gbh_pkg;

  // Default sizes of the counter store.
  localparam int MAX_BINS_DEFAULT    = 256;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Width of every field and of the reported count.
  localparam int PIX_W       = 8;
  localparam int BIN_W       = 8;
  localparam int LOG2_W      = 4;
  localparam int OUT_COUNT_W = 32;

  // Reset value of the bins_log2 register.
  localparam logic [LOG2_W-1:0] BINS_LOG2_RESET = 4'd8;

  // Luma weights in percent and the reciprocal of 100 in Q19.
  localparam int SUM_W       = 15;
  localparam int W_RED       = 30;
  localparam int W_GREEN     = 59;
  localparam int W_BLUE      = 11;
  localparam int RECIP_W     = 13;
  localparam int GRAY_RECIP  = 5243;
  localparam int GRAY_SHIFT  = 19;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Output queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Operation presented to the counter store from the last stage.
  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [BIN_W-1:0] bin;
  } bin_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [PIX_W-1:0]       range_low;
    logic [PIX_W-1:0]       range_high;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic                   index_valid;
  } result_t;

endpackage

// ===== rtl/gray_binned_histogram_core.sv =====
// ----------------------------------------------------------------------------
// Gray binned histogram core
// Converts RGB pixels to gray, counts them in selectable bins, reads and clears.
// ----------------------------------------------------------------------------
// A read result passes stages A, B and C and is written into the output queue before it is offered.
// Throughput: one transaction per cycle while the output queue is empty; input
// stalls when queued results plus transactions in flight reach four, so a run of
// reads into an always-ready output stalls when one result is queued and three are in flight.
// Reset: all counters read as zero and bins_log2 is 8 right after reset; valid
// bits clear the store at once, so there is no clearing pass.
module gray_binned_histogram_core #(
  parameter int MAX_BINS    = gbh_pkg::MAX_BINS_DEFAULT,
  parameter int COUNT_WIDTH = gbh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbh_pkg::LOG2_W-1:0]          cfg_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic [gbh_pkg::PIX_W-1:0]           red,
  input  logic [gbh_pkg::PIX_W-1:0]           green,
  input  logic [gbh_pkg::PIX_W-1:0]           blue,
  input  logic [gbh_pkg::BIN_W-1:0]           bin_index,
  // Output channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gbh_pkg::PIX_W-1:0]           range_low,
  output logic [gbh_pkg::PIX_W-1:0]           range_high,
  output logic [gbh_pkg::OUT_COUNT_W-1:0]     bin_count,
  output logic                                index_valid
);

  localparam int STORE_LOG2 = $clog2(MAX_BINS + 1) - 1;
  localparam int PEND_W     = gbh_pkg::FIFO_CNT_W + 1;

  // Configuration register.
  logic [gbh_pkg::LOG2_W-1:0] bins_log2;
  logic [gbh_pkg::LOG2_W-1:0] eff_log2;
  logic [gbh_pkg::LOG2_W-1:0] bin_shift;

  // Stage A: accepted transaction.
  logic                           a_vld;
  gbh_pkg::op_t                   a_op;
  logic [gbh_pkg::PIX_W-1:0]      a_red;
  logic [gbh_pkg::PIX_W-1:0]      a_green;
  logic [gbh_pkg::PIX_W-1:0]      a_blue;
  logic [gbh_pkg::BIN_W-1:0]      a_idx;
  logic [gbh_pkg::SUM_W-1:0]      a_sum;

  // Stage B: weighted sum, gray level and bin lookup.
  logic                           b_vld;
  gbh_pkg::op_t                   b_op;
  logic [gbh_pkg::SUM_W-1:0]      b_sum;
  logic [gbh_pkg::BIN_W-1:0]      b_idx;
  logic [gbh_pkg::PROD_W-1:0]     b_prod;
  logic [gbh_pkg::PIX_W-1:0]      b_gray;
  logic [gbh_pkg::BIN_W-1:0]      b_bin;
  logic                           b_in_range;
  logic [gbh_pkg::PIX_W-1:0]      b_low;
  logic [gbh_pkg::PIX_W-1:0]      b_high;

  // Stage C: counter update or read result.
  logic                           c_vld;
  gbh_pkg::op_t                   c_op;
  logic [gbh_pkg::BIN_W-1:0]      c_bin;
  logic                           c_in_range;
  logic [gbh_pkg::PIX_W-1:0]      c_low;
  logic [gbh_pkg::PIX_W-1:0]      c_high;
  logic [COUNT_WIDTH-1:0]         c_count;
  logic [gbh_pkg::OUT_COUNT_W-1:0] c_count_sat;
  gbh_pkg::bin_cmd_t              c_cmd;
  gbh_pkg::result_t               c_result;
  logic                           c_push;

  // Output queue.
  gbh_pkg::result_t                 fifo_head;
  logic [gbh_pkg::FIFO_CNT_W-1:0]   fifo_count;
  logic [PEND_W-1:0]                pending;

  // Configuration write; values above the store size act as the store size.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_log2 <= gbh_pkg::BINS_LOG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bins_log2 <= cfg_data;
    end
  end

  assign eff_log2  = (bins_log2 > gbh_pkg::LOG2_W'(STORE_LOG2))
                     ? gbh_pkg::LOG2_W'(STORE_LOG2) : bins_log2;
  assign bin_shift = gbh_pkg::LOG2_W'(gbh_pkg::PIX_W) - eff_log2;

  // Accept while every transaction in flight still has a queue slot waiting.
  assign pending  = PEND_W'(fifo_count) + PEND_W'(a_vld) + PEND_W'(b_vld)
                    + PEND_W'(c_vld);
  assign in_ready = (pending < PEND_W'(gbh_pkg::FIFO_DEPTH));

  // Pipeline valid bits; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= in_valid && in_ready;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  // Stage A capture.
  always_ff @(posedge clk) begin
    a_op    <= gbh_pkg::op_t'(op);
    a_red   <= red;
    a_green <= green;
    a_blue  <= blue;
    a_idx   <= bin_index;
  end

  // Weighted sum 30R + 59G + 11B, at most 25500.
  assign a_sum = gbh_pkg::SUM_W'(a_red)   * gbh_pkg::SUM_W'(gbh_pkg::W_RED)
               + gbh_pkg::SUM_W'(a_green) * gbh_pkg::SUM_W'(gbh_pkg::W_GREEN)
               + gbh_pkg::SUM_W'(a_blue)  * gbh_pkg::SUM_W'(gbh_pkg::W_BLUE);

  always_ff @(posedge clk) begin
    b_op  <= a_op;
    b_sum <= a_sum;
    b_idx <= a_idx;
  end

  // Divide by 100 through the Q19 reciprocal; exact for sums up to 25500.
  assign b_prod = gbh_pkg::PROD_W'(b_sum)
                  * gbh_pkg::PROD_W'(gbh_pkg::GRAY_RECIP);
  assign b_gray = b_prod[gbh_pkg::GRAY_SHIFT +: gbh_pkg::PIX_W];

  // Bin selection and the gray range of a read bin.
  always_comb begin
    if (b_op == gbh_pkg::OP_COUNT) begin
      b_bin = b_gray >> bin_shift;
    end else begin
      b_bin = b_idx;
    end
  end

  assign b_in_range = ((b_idx >> eff_log2) == '0);
  assign b_low      = b_idx << bin_shift;
  assign b_high     = b_low | (gbh_pkg::PIX_W'(8'hFF) >> eff_log2);

  always_ff @(posedge clk) begin
    c_op       <= b_op;
    c_bin      <= b_bin;
    c_in_range <= b_in_range;
    c_low      <= b_low;
    c_high     <= b_high;
  end

  // Counter store: lookup from stage B, update or read in stage C.
  assign c_cmd = '{vld: c_vld, op: c_op, bin: c_bin};

  gbh_bin_store #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .lookup_bin (b_bin),
    .cmd        (c_cmd),
    .count      (c_count)
  );

  // Reported count saturates at the output width.
  generate
    if (COUNT_WIDTH > gbh_pkg::OUT_COUNT_W) begin : g_sat
      assign c_count_sat = (|c_count[COUNT_WIDTH-1:gbh_pkg::OUT_COUNT_W])
                           ? '1 : c_count[gbh_pkg::OUT_COUNT_W-1:0];
    end else begin : g_ext
      assign c_count_sat = gbh_pkg::OUT_COUNT_W'(c_count);
    end
  endgenerate

  // Read result; an index beyond the bin count reports all zeros.
  always_comb begin
    if (c_in_range) begin
      c_result = '{range_low: c_low, range_high: c_high,
                   bin_count: c_count_sat, index_valid: 1'b1};
    end else begin
      c_result = '{range_low: '0, range_high: '0,
                   bin_count: '0, index_valid: 1'b0};
    end
  end

  assign c_push = c_vld && (c_op == gbh_pkg::OP_READ);

  gbh_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (c_push),
    .push_data (c_result),
    .pop       (out_ready),
    .head      (fifo_head),
    .not_empty (out_valid),
    .count     (fifo_count)
  );

  assign range_low   = fifo_head.range_low;
  assign range_high  = fifo_head.range_high;
  assign bin_count   = fifo_head.bin_count;
  assign index_valid = fifo_head.index_valid;

  // Queued results plus transactions in flight never exceed the queue size.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(gbh_pkg::FIFO_DEPTH))
    else $error("more transactions in flight than queue slots");

endmodule

// ===== rtl/gbh_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Gray binned histogram output queue
// Small queue that holds read results until the downstream side takes them.
// ----------------------------------------------------------------------------
module gbh_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  gbh_pkg::result_t                  push_data,
  input  logic                              pop,
  output gbh_pkg::result_t                  head,
  output logic                              not_empty,
  output logic [gbh_pkg::FIFO_CNT_W-1:0]    count
);

  gbh_pkg::result_t                   slots [gbh_pkg::FIFO_DEPTH];
  logic [gbh_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [gbh_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic                               do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The credit check upstream must keep a slot free for every result.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != gbh_pkg::FIFO_CNT_W'(gbh_pkg::FIFO_DEPTH)))
    else $error("output queue written while full");

endmodule

// ===== rtl/gbh_bin_store.sv =====
// ----------------------------------------------------------------------------
// Gray binned histogram counter store
// Counter memory with per-entry valid bits, read-modify-write and forwarding.
// ----------------------------------------------------------------------------
module gbh_bin_store #(
  parameter int MAX_BINS    = gbh_pkg::MAX_BINS_DEFAULT,
  parameter int COUNT_WIDTH = gbh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gbh_pkg::BIN_W-1:0]    lookup_bin,
  input  gbh_pkg::bin_cmd_t            cmd,
  output logic [COUNT_WIDTH-1:0]       count
);

  localparam int ADDR_W = $clog2(MAX_BINS + 1) - 1;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_q;
  logic [DEPTH-1:0]       valid_bits;
  logic                   fwd;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [ADDR_W-1:0]      lookup_addr;
  logic [ADDR_W-1:0]      cmd_addr;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   wr_en;
  logic                   clr_en;

  assign lookup_addr = lookup_bin[ADDR_W-1:0];
  assign cmd_addr    = cmd.bin[ADDR_W-1:0];
  assign wr_en       = cmd.vld && (cmd.op == gbh_pkg::OP_COUNT);
  assign clr_en      = cmd.vld && (cmd.op == gbh_pkg::OP_CLEAR);

  // Current count: a write from the cycle before wins, a cleared entry reads zero.
  always_comb begin
    if (fwd) begin
      count = fwd_data;
    end else if (valid_bits[cmd_addr]) begin
      count = mem_q;
    end else begin
      count = '0;
    end
  end

  // Saturating increment.
  assign count_inc = (&count) ? count : count + COUNT_WIDTH'(1);

  // Counter memory, one read and one write port.
  always_ff @(posedge clk) begin
    mem_q <= mem[lookup_addr];
    if (wr_en) begin
      mem[cmd_addr] <= count_inc;
    end
  end

  // The written value is kept for a lookup of the same bin in the same cycle.
  always_ff @(posedge clk) begin
    fwd_data <= count_inc;
  end

  // Valid bits and forward flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      fwd        <= 1'b0;
    end else begin
      fwd <= wr_en && (cmd_addr == lookup_addr);
      if (clr_en) begin
        valid_bits <= '0;
      end else if (wr_en) begin
        valid_bits[cmd_addr] <= 1'b1;
      end
    end
  end

  // Forwarding is only ever armed by a counter update.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(wr_en))
    else $error("forward flag set without a preceding update");

  // A clear empties every entry at once.
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    clr_en |=> (valid_bits == '0))
    else $error("entries still valid after clear");

endmodule
